FILE: rtl/plp_pkg.sv
package plp_pkg;

    // Parse phases of the placement list.
    typedef enum logic [2:0] {
        PH_OBJ_FIRST  = 3'd0,
        PH_OBJ_SECOND = 3'd1,
        PH_LOC_FIRST  = 3'd2,
        PH_LOC_SECOND = 3'd3,
        PH_PACKED     = 3'd4,
        PH_CUST_FLAGS = 3'd5,
        PH_SKIP       = 3'd6,
        PH_DONE       = 3'd7
    } t_phase;

    localparam logic [14:0] CHAIN_MARK = 15'h7FFF;
    localparam logic [19:0] LOC_MAX    = 20'hFFFFF;
    localparam logic [30:0] ID_MAX     = 31'h7FFFFFFF;

    // One input transaction: a byte of the list and its end marker.
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       is_final;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic        has_placement;
        logic [30:0] object_ident;
        logic [5:0]  local_x;
        logic [5:0]  local_y;
        logic [1:0]  plane_level;
        logic [4:0]  shape_code;
        logic [1:0]  rotation_code;
        logic        list_end;
    } t_out_item;

    // Number of customization bytes that follow a flag byte.
    function automatic logic [4:0] skip_count(input logic [7:0] f);
        logic [4:0] n;
        n = 5'd0;
        if (f[0]) n = n + 5'd8;
        if (f[1]) n = n + 5'd2;
        if (f[2]) n = n + 5'd2;
        if (f[3]) n = n + 5'd2;
        if (f[4]) begin
            n = n + 5'd2;
        end else begin
            if (f[5]) n = n + 5'd2;
            if (f[6]) n = n + 5'd2;
            if (f[7]) n = n + 5'd2;
        end
        return n;
    endfunction

endpackage

FILE: rtl/plp_if.sv
// Input channel: one list byte per transaction.
interface plp_in_if
    import plp_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel: one placement or end marker per transaction.
interface plp_out_if
    import plp_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/placement_list_parser.sv
// Placement list parser.
// Input channel i_in carries one byte of the list per transaction, with
// is_final set on the last byte. Output channel o_res carries one result
// per placement found (on its packed shape/rotation byte, plane below 4)
// and always one result for the final byte, with list_end set.
// A byte is taken in every cycle while the output side keeps up, so the
// sustained rate is one byte per cycle. Each result is registered before
// it appears on o_res, never driven straight from its byte. The parser state is
// updated in the cycle a byte is taken; the result goes into an output
// register backed by one skid register, so i_in.ready depends only on
// registers. When the receiver stalls, the output register holds its
// transaction, one more result fills the skid register, and then
// i_in.ready drops until the receiver takes a transaction.
// Synchronous active-low reset empties both registers and returns the
// parser to the start of a list with the object id at minus one.
module placement_list_parser
    import plp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    plp_in_if.sink   i_in,
    plp_out_if.source o_res
);

    logic      accept;
    logic      take;
    logic      res_valid;
    t_out_item res;

    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_skid_valid;
    t_out_item r_skid_data;

    assign i_in.ready  = !r_skid_valid;
    assign accept      = i_in.valid && !r_skid_valid;
    assign take        = r_out_valid && o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    plp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in.data),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    // Output register and skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : res;
        end else if (accept && res_valid) begin
            r_skid_data <= res;
        end
    end

`ifndef SYNTHESIS
    // The skid register is only used behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // A final byte always produces a result transaction.
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.data.is_final) |=> r_out_valid)
        else $error("final byte produced no result");

    // A stalled result is never dropped.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid)
        else $error("stalled result lost");
`endif

endmodule

FILE: rtl/plp_core.sv
module plp_core
    import plp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_result
);

    t_phase      r_phase,  n_phase;
    logic [31:0] r_cur,    n_cur;
    logic [30:0] r_delta,  n_delta;
    logic [19:0] r_loc,    n_loc;
    logic [7:0]  r_high,   n_high;
    logic [4:0]  r_skip,   n_skip;

    logic [7:0]  b;
    logic        fin;
    logic [14:0] v;
    logic        obj_done;
    logic        loc_done;
    logic        emit;
    logic [31:0] chain_sum;
    logic [31:0] incr;
    logic [32:0] obj_sum;
    logic [20:0] loc_sum;
    logic [4:0]  skip_dec;

    assign b   = i_item.stream_byte;
    assign fin = i_item.is_final;

    // Smart value: one byte, or two bytes with the bias removed.
    assign v = (r_phase == PH_OBJ_SECOND || r_phase == PH_LOC_SECOND)
             ? {r_high[6:0], b} : {7'd0, b};

    // Accumulator arithmetic with saturation.
    assign chain_sum = {1'b0, r_delta} + {17'd0, CHAIN_MARK};
    assign incr      = {1'b0, r_delta} + {17'd0, v};
    assign obj_sum   = {r_cur[31], r_cur} + {1'b0, incr};
    assign loc_sum   = {1'b0, r_loc} + {6'd0, v} - 21'd1;
    assign skip_dec  = r_skip - {4'd0, (r_skip != 5'd0)};

    // Next-state logic for the parse phase and the accumulators.
    always_comb begin
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_delta  = r_delta;
        n_loc    = r_loc;
        n_high   = r_high;
        n_skip   = r_skip;
        obj_done = 1'b0;
        loc_done = 1'b0;
        unique case (r_phase)
            PH_OBJ_FIRST: begin
                if (b[7]) begin
                    n_high  = b;
                    n_phase = PH_OBJ_SECOND;
                end else begin
                    obj_done = 1'b1;
                end
            end
            PH_LOC_FIRST: begin
                if (b[7]) begin
                    n_high  = b;
                    n_phase = PH_LOC_SECOND;
                end else begin
                    loc_done = 1'b1;
                end
            end
            PH_OBJ_SECOND: obj_done = 1'b1;
            PH_LOC_SECOND: loc_done = 1'b1;
            PH_PACKED: begin
                n_phase = b[7] ? PH_CUST_FLAGS : PH_LOC_FIRST;
            end
            PH_CUST_FLAGS: begin
                n_skip  = skip_count(b);
                n_phase = (skip_count(b) == 5'd0) ? PH_LOC_FIRST : PH_SKIP;
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 5'd0) n_phase = PH_LOC_FIRST;
            end
            PH_DONE: n_phase = PH_DONE;
        endcase

        // A completed object delta either chains, ends the list or opens a group.
        if (obj_done) begin
            if (v == CHAIN_MARK) begin
                n_delta = chain_sum[31] ? ID_MAX : chain_sum[30:0];
                n_phase = PH_OBJ_FIRST;
            end else begin
                n_delta = 31'd0;
                if (incr == 32'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_cur   = (obj_sum[32:31] != 2'b00) ? {1'b0, ID_MAX} : obj_sum[31:0];
                    n_loc   = 20'd0;
                    n_phase = PH_LOC_FIRST;
                end
            end
        end

        // A completed location step closes the group or moves the location.
        if (loc_done) begin
            if (v == 15'd0) begin
                n_phase = PH_OBJ_FIRST;
            end else begin
                n_loc   = loc_sum[20] ? LOC_MAX : loc_sum[19:0];
                n_phase = PH_PACKED;
            end
        end

        // The final byte returns everything to its reset values.
        if (fin) begin
            n_phase = PH_OBJ_FIRST;
            n_cur   = '1;
            n_delta = 31'd0;
            n_loc   = 20'd0;
            n_high  = 8'd0;
            n_skip  = 5'd0;
        end
    end

    // Result for the byte being taken.
    always_comb begin
        emit     = (r_phase == PH_PACKED) && (r_loc[19:14] == 6'd0);
        o_result = '0;
        if (emit) begin
            o_result.has_placement = 1'b1;
            o_result.object_ident  = r_cur[30:0];
            o_result.local_x       = r_loc[11:6];
            o_result.local_y       = r_loc[5:0];
            o_result.plane_level   = r_loc[13:12];
            o_result.shape_code    = b[6:2];
            o_result.rotation_code = b[1:0];
        end
        o_result.list_end = fin;
        o_res_valid       = emit || fin;
    end

    // Parser state registers, updated on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OBJ_FIRST;
            r_cur   <= '1;
            r_delta <= 31'd0;
            r_loc   <= 20'd0;
            r_high  <= 8'd0;
            r_skip  <= 5'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_delta <= n_delta;
            r_loc   <= n_loc;
            r_high  <= n_high;
            r_skip  <= n_skip;
        end
    end

`ifndef SYNTHESIS
    // The object id is either the start value or a valid nonnegative id.
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur[31] |-> (r_cur == 32'hFFFFFFFF))
        else $error("object id left its legal range");

    // The skip phase always has bytes left to skip.
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != 5'd0))
        else $error("skip phase with empty count");

    // After the final byte the parser is back at the start of a list.
    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && fin) |=> (r_phase == PH_OBJ_FIRST && r_delta == 31'd0))
        else $error("parser not restarted after final byte");
`endif

endmodule

FILE: bench/tb_placement_list_parser.sv
module tb_placement_list_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import plp_pkg::*;

    localparam int     QUIET_LIMIT = 2000;
    localparam int     DRAIN_CYCLES = 8;
    localparam longint ID_CEILING = longint'(ID_MAX);
    localparam int     LOC_CEILING = int'(LOC_MAX);

    logic i_clk;
    logic i_rst_n;

    plp_in_if  list_if();
    plp_out_if place_if();

    placement_list_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (list_if),
        .o_res   (place_if)
    );

    // Idle percentages of the sender and the receiver for the current phase.
    int send_idle_pct;
    int recv_stall_pct;

    // Run statistics.
    int mismatch_count;
    int bytes_sent;
    int results_checked;
    int lists_sent;
    int quiet_cycles;

    // Placements expected from the parser, oldest first.
    t_out_item pending_placements[$];

    // Shadow copy of the parser state.
    t_phase     shadow_phase;
    longint     shadow_object;
    longint     shadow_chain;
    int         shadow_location;
    logic [7:0] shadow_high;
    int         shadow_skip;

    // Byte list under construction for the random lists.
    logic [7:0] list_bytes[$];
    int         packed_spots[$];

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: ready is dropped at random according to the stall rate.
    initial begin
        place_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            place_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge i_clk) begin
        if ((list_if.valid && list_if.ready) || (place_if.valid && place_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_placements.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker: each output transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && place_if.valid && place_if.ready) begin
            got = place_if.data;
            results_checked++;
            if (pending_placements.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_placements.pop_front();
                check_field("has_placement", want.has_placement, got.has_placement);
                check_field("object_ident", want.object_ident, got.object_ident);
                check_field("local_x", want.local_x, got.local_x);
                check_field("local_y", want.local_y, got.local_y);
                check_field("plane_level", want.plane_level, got.plane_level);
                check_field("shape_code", want.shape_code, got.shape_code);
                check_field("rotation_code", want.rotation_code, got.rotation_code);
                check_field("list_end", want.list_end, got.list_end);
            end
        end
    end

    // Number of customization bytes announced by a flag byte.
    function automatic int custom_skip_len(logic [7:0] flags);
        int n;
        n = flags[0] ? 8 : 0;
        n += 2 * (int'(flags[1]) + int'(flags[2]) + int'(flags[3]) + int'(flags[4]));
        if (!flags[4]) n += 2 * (int'(flags[5]) + int'(flags[6]) + int'(flags[7]));
        return n;
    endfunction

    task automatic clear_shadow();
        shadow_phase    = PH_OBJ_FIRST;
        shadow_object   = -1;
        shadow_chain    = 0;
        shadow_location = 0;
        shadow_high     = 8'h00;
        shadow_skip     = 0;
    endtask

    // A complete object delta: chain marks accumulate, zero ends the list.
    task automatic finish_object_delta(input int value);
        longint incr;
        if (value == int'(CHAIN_MARK)) begin
            shadow_chain = shadow_chain + value;
            if (shadow_chain > ID_CEILING) shadow_chain = ID_CEILING;
            shadow_phase = PH_OBJ_FIRST;
        end else begin
            incr = shadow_chain + value;
            shadow_chain = 0;
            if (incr == 0) begin
                shadow_phase = PH_DONE;
            end else begin
                shadow_object = shadow_object + incr;
                if (shadow_object > ID_CEILING) shadow_object = ID_CEILING;
                shadow_location = 0;
                shadow_phase = PH_LOC_FIRST;
            end
        end
    endtask

    // A complete location step: zero closes the group.
    task automatic finish_location_step(input int value);
        if (value == 0) begin
            shadow_phase = PH_OBJ_FIRST;
        end else begin
            shadow_location = shadow_location + value - 1;
            if (shadow_location > LOC_CEILING) shadow_location = LOC_CEILING;
            shadow_phase = PH_PACKED;
        end
    endtask

    // Advances the shadow parser by one accepted byte and queues any result.
    task automatic predict_placement(input logic [7:0] b, input logic fin);
        t_out_item  res;
        logic [15:0] two_byte;
        logic [19:0] loc;
        bit          emit;
        res  = '0;
        emit = 1'b0;
        loc  = shadow_location[19:0];
        case (shadow_phase)
            PH_OBJ_FIRST, PH_LOC_FIRST: begin
                if (!b[7]) begin
                    if (shadow_phase == PH_OBJ_FIRST) finish_object_delta(int'(b));
                    else finish_location_step(int'(b));
                end else begin
                    shadow_high  = b;
                    shadow_phase = (shadow_phase == PH_OBJ_FIRST) ? PH_OBJ_SECOND
                                                                  : PH_LOC_SECOND;
                end
            end
            PH_OBJ_SECOND, PH_LOC_SECOND: begin
                two_byte = {shadow_high, b} - 16'h8000;
                if (shadow_phase == PH_OBJ_SECOND) finish_object_delta(int'(two_byte));
                else finish_location_step(int'(two_byte));
            end
            PH_PACKED: begin
                // Placements on plane 4 and above are dropped.
                if (loc[19:14] == 6'd0) begin
                    emit                = 1'b1;
                    res.has_placement   = 1'b1;
                    res.object_ident    = shadow_object[30:0];
                    res.local_x         = loc[11:6];
                    res.local_y         = loc[5:0];
                    res.plane_level     = loc[13:12];
                    res.shape_code      = b[6:2];
                    res.rotation_code   = b[1:0];
                end
                shadow_phase = b[7] ? PH_CUST_FLAGS : PH_LOC_FIRST;
            end
            PH_CUST_FLAGS: begin
                shadow_skip  = custom_skip_len(b);
                shadow_phase = (shadow_skip == 0) ? PH_LOC_FIRST : PH_SKIP;
            end
            PH_SKIP: begin
                if (shadow_skip > 0) shadow_skip--;
                if (shadow_skip == 0) shadow_phase = PH_LOC_FIRST;
            end
            default: begin
                shadow_phase = PH_DONE;
            end
        endcase
        if (fin) begin
            res.list_end = 1'b1;
            clear_shadow();
            pending_placements.insert(pending_placements.size(), res);
        end else if (emit) begin
            pending_placements.insert(pending_placements.size(), res);
        end
    endtask

    // Sends one list byte, with random idle cycles ahead of it.
    task automatic send_list_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            list_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        list_if.valid <= 1'b1;
        list_if.data  <= '{stream_byte: b, is_final: fin};
        do @(posedge i_clk); while (!list_if.ready);
        predict_placement(b, fin);
        bytes_sent++;
        if (fin) lists_sent++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Adds one byte at the end of the list under construction.
    task automatic append_byte(input logic [7:0] b);
        list_bytes.insert(list_bytes.size(), b);
    endtask

    // Appends a short integer; small values may still use the two-byte form.
    task automatic push_smart(input int value, input bit two_bytes);
        logic [14:0] v;
        v = value[14:0];
        if (value < 128 && !two_bytes) begin
            append_byte({1'b0, v[6:0]});
        end else begin
            append_byte({1'b1, v[14:8]});
            append_byte(v[7:0]);
        end
    endtask

    // Appends an object delta, split into chain marks where needed.
    task automatic push_delta(input int value);
        int rest;
        rest = value;
        while (rest >= int'(CHAIN_MARK)) begin
            push_smart(int'(CHAIN_MARK), 1'b1);
            rest -= int'(CHAIN_MARK);
        end
        push_smart(rest, ($urandom_range(0, 7) == 0));
    endtask

    // Builds one list with random content and sends it, often cut short.
    task automatic send_random_list();
        int         delta;
        int         step;
        int         cut;
        int         k;
        logic [7:0] shape_byte;
        logic [7:0] flags;
        list_bytes.delete();
        packed_spots.delete();
        if ($urandom_range(0, 9) == 0) begin
            // Plain noise.
            repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 19))
                    0:       delta = 0;
                    1, 2:    delta = int'(CHAIN_MARK) * $urandom_range(1, 2)
                                     + $urandom_range(0, 200);
                    3, 4, 5: delta = $urandom_range(128, 32766);
                    default: delta = $urandom_range(1, 127);
                endcase
                push_delta(delta);
                repeat ($urandom_range(0, 4)) begin
                    step = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 32767)
                                                       : $urandom_range(1, 127);
                    push_smart(step, ($urandom_range(0, 5) == 0));
                    shape_byte    = 8'($urandom);
                    shape_byte[7] = ($urandom_range(0, 2) == 0);
                    packed_spots.insert(packed_spots.size(), list_bytes.size());
                    append_byte(shape_byte);
                    if (shape_byte[7]) begin
                        flags = 8'($urandom);
                        append_byte(flags);
                        repeat (custom_skip_len(flags)) append_byte(8'($urandom));
                    end
                end
                push_smart(0, ($urandom_range(0, 9) == 0));
            end
            // Closing zero delta, then bytes that the parser ignores.
            push_smart(0, 1'b0);
            repeat ($urandom_range(0, 2)) append_byte(8'($urandom));
            append_byte(8'($urandom));
        end
        cut = list_bytes.size() - 1;
        case ($urandom_range(0, 4))
            2: if (packed_spots.size() > 0)
                   cut = packed_spots[$urandom_range(0, packed_spots.size() - 1)];
            3: cut = $urandom_range(0, list_bytes.size() - 1);
            default: ;
        endcase
        for (k = 0; k <= cut; k++) send_list_byte(list_bytes[k], (k == cut));
    endtask

    // One- and two-byte integers, chaining, customization skips, plane drop.
    task automatic test_smart_and_chain();
        set_idling(38, 38);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h05, 1'b0);
        send_list_byte(8'h7F, 1'b0);
        send_list_byte(8'h80, 1'b0);
        send_list_byte(8'h41, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'hFF, 1'b0);
        send_list_byte(8'hFF, 1'b0);
        send_list_byte(8'h02, 1'b0);
        send_list_byte(8'h81, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'hFE, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'hB1, 1'b0);
        send_list_byte(8'h30, 1'b0);
        send_list_byte(8'hFF, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'hC0, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h05, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'hAA, 1'b0);
        send_list_byte(8'h55, 1'b1);
    endtask

    // The final byte landing on a packed byte, on object deltas and on a skipped customization byte.
    task automatic test_list_end_cases();
        set_idling(0, 49);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h22, 1'b1);
        send_list_byte(8'h85, 1'b1);
        send_list_byte(8'h03, 1'b1);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h80, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h11, 1'b0);
        send_list_byte(8'h22, 1'b0);
        send_list_byte(8'h33, 1'b1);
        send_list_byte(8'h00, 1'b1);
    endtask

    // Location climbs past its ceiling, then restarts for the next object.
    task automatic test_location_saturation();
        set_idling(0, 0);
        send_list_byte(8'h01, 1'b0);
        repeat (34) begin
            send_list_byte(8'hFF, 1'b0);
            send_list_byte(8'hFF, 1'b0);
            send_list_byte(8'h4A, 1'b0);
        end
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h03, 1'b1);
    endtask

    // A few chain marks add up in the pending delta before it reaches the object id.
    task automatic test_delta_chain();
        set_idling(0, 0);
        repeat (3) begin
            send_list_byte(8'hFF, 1'b0);
            send_list_byte(8'hFF, 1'b0);
        end
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h01, 1'b0);
        send_list_byte(8'h04, 1'b0);
        send_list_byte(8'h00, 1'b0);
        send_list_byte(8'h05, 1'b0);
        send_list_byte(8'h02, 1'b0);
        send_list_byte(8'h09, 1'b1);
    endtask

    // Random lists under one idling setting.
    task automatic test_random_lists(input int send_pct, input int recv_pct,
                                     input int byte_goal);
        int start;
        set_idling(send_pct, recv_pct);
        start = bytes_sent;
        while (bytes_sent - start < byte_goal) send_random_list();
    endtask

    // Reset, test sequence and final verdict.
    initial begin
        mismatch_count  = 0;
        bytes_sent      = 0;
        results_checked = 0;
        lists_sent      = 0;
        quiet_cycles    = 0;
        set_idling(0, 0);
        clear_shadow();
        i_rst_n       <= 1'b0;
        list_if.valid <= 1'b0;
        list_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_smart_and_chain();
        test_list_end_cases();
        test_location_saturation();
        test_delta_chain();
        test_random_lists(0, 0, 50);
        test_random_lists(49, 0, 50);
        test_random_lists(0, 49, 50);
        test_random_lists(38, 38, 50);
        list_if.valid <= 1'b0;

        while (pending_placements.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d lists, checked %0d results.",
                 bytes_sent, lists_sent, results_checked);
        $display("Covered chained ids, location saturation, skips, plane drops and list ends.");
        if (mismatch_count == 0 && pending_placements.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
